// File: src/hst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_pkg: shared definitions for the reachable heading set tracker
// Request codes, heading circle size and the widths derived from it.
// ----------------------------------------------------------------------------
package hst_pkg;

  // Number of heading steps in one full turn.
  localparam int HEADING_STEPS = 360;

  // Field widths of the request and result channels.
  localparam int REQ_W    = 3;
  localparam int AMOUNT_W = 9;
  localparam int SUM_W    = 32;
  localparam int ANGLE_W  = 8;

  // Width of a rotation amount, and of the work value used to fold the
  // request amount into one turn.
  localparam int SHIFT_W = $clog2(HEADING_STEPS);
  localparam int WORK_W  = ((AMOUNT_W > SHIFT_W) ? AMOUNT_W : SHIFT_W) + 1;

  // Compare-and-subtract passes needed to bring any amount below one turn.
  localparam int TURN_FOLDS = ((2 ** AMOUNT_W) - 1) / HEADING_STEPS;

  // Largest deviation from heading zero.
  localparam int HALF_STEPS = HEADING_STEPS / 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FORWARD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BACKWARD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LEFT     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RIGHT    = 3'd4;

  typedef logic [HEADING_STEPS-1:0] heading_set_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [SHIFT_W-1:0]       shift_t;

  // Set after reset or clear: only heading zero reachable.
  localparam heading_set_t SET_RESET = heading_set_t'(1);

endpackage

// File: src/hst_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_rotate: optional turn of the heading set
// Returns the old set OR the old set rotated up by the shift amount.
// ----------------------------------------------------------------------------
module hst_rotate (
  input  hst_pkg::heading_set_t set_i,
  input  hst_pkg::shift_t       shift,
  output hst_pkg::heading_set_t set_o
);

  logic [2*hst_pkg::HEADING_STEPS-1:0] dbl;
  logic [2*hst_pkg::HEADING_STEPS-1:0] shifted;

  // Rotating the doubled vector and taking the upper copy wraps the circle.
  assign dbl     = {set_i, set_i};
  assign shifted = dbl << shift;
  assign set_o   = set_i | shifted[2*hst_pkg::HEADING_STEPS-1:hst_pkg::HEADING_STEPS];

endmodule

// File: src/hst_best_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_best_angle: search for the reachable heading farthest from zero
// Folds the circle onto deviations 0 to half a turn and picks the highest.
// ----------------------------------------------------------------------------
module hst_best_angle (
  input  hst_pkg::heading_set_t        set_i,
  output logic [hst_pkg::ANGLE_W-1:0]  best
);

  logic [hst_pkg::HALF_STEPS:0] fold;

  // A deviation d is reachable through heading d or heading N - d.
  always_comb begin
    fold[0] = set_i[0];
    for (int d = 1; d <= hst_pkg::HALF_STEPS; d++) begin
      fold[d] = set_i[d] | set_i[hst_pkg::HEADING_STEPS - d];
    end
  end

  always_comb begin
    best = '0;
    for (int d = 0; d <= hst_pkg::HALF_STEPS; d++) begin
      if (fold[d]) begin
        best = hst_pkg::ANGLE_W'(d);
      end
    end
  end

endmodule

// File: src/reachable_heading_set_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reachable_heading_set_tracker: heading set and distance sum tracker
// Keeps the set of reachable headings under optional turns and two saturating
// distance sums, and reports the sums and best angle for every request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_ready  in_req_type, in_amount
//   out_      output     out_valid/out_ready  out_forward_total,
//                                             out_backward_total, out_best_angle
//
// Takes one request per cycle while the output is not stalled. A request is
// held in the input register and is then processed in a single pass (turn
// rotation, sum update and best angle search) into the result register, from
// which it can be taken at any edge where the output is not stalled.
// Reset is synchronous and active low; it empties both stages and returns the
// set to heading zero only and the sums to zero.
// While the result register is stalled, the input register can still take one
// more request, so the input side does not stop at once when a stall begins.
// ----------------------------------------------------------------------------
module reachable_heading_set_tracker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [8:0]  in_amount,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_forward_total,
  output logic [31:0] out_backward_total,
  output logic [7:0]  out_best_angle
);

  // Input register stage.
  logic                               s1_vld_r;
  logic [hst_pkg::REQ_W-1:0]          s1_req_r;
  logic [hst_pkg::AMOUNT_W-1:0]       s1_amount_r;

  // Tracker state.
  hst_pkg::heading_set_t              set_r;
  hst_pkg::heading_set_t              set_nxt;
  hst_pkg::sum_t                      fwd_sum_r;
  hst_pkg::sum_t                      fwd_sum_nxt;
  hst_pkg::sum_t                      bwd_sum_r;
  hst_pkg::sum_t                      bwd_sum_nxt;

  // Result register stage.
  logic                               out_vld_r;
  hst_pkg::sum_t                      out_fwd_r;
  hst_pkg::sum_t                      out_bwd_r;
  logic [hst_pkg::ANGLE_W-1:0]        out_best_r;

  logic                               out_adv;
  logic                               s1_fire;
  logic                               in_fire;

  logic [hst_pkg::WORK_W-1:0]         turn_work;
  hst_pkg::shift_t                    turn;
  hst_pkg::shift_t                    shift;
  hst_pkg::heading_set_t              turned_set;
  logic [hst_pkg::ANGLE_W-1:0]        best_nxt;
  logic [hst_pkg::SUM_W:0]            fwd_add;
  logic [hst_pkg::SUM_W:0]            bwd_add;

  // The result register frees up when it is empty or being read. The input
  // register moves its request forward whenever the result register frees up,
  // and so can take a new request in the same cycle.
  assign out_adv  = !out_vld_r || out_ready;
  assign s1_fire  = s1_vld_r && out_adv;
  assign in_ready = !s1_vld_r || out_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r    <= in_req_type;
      s1_amount_r <= in_amount;
    end
  end

  // Reduce the turn amount into one full turn.
  always_comb begin
    turn_work = hst_pkg::WORK_W'(s1_amount_r);
    for (int k = 0; k < hst_pkg::TURN_FOLDS; k++) begin
      if (turn_work >= hst_pkg::WORK_W'(hst_pkg::HEADING_STEPS)) begin
        turn_work = turn_work - hst_pkg::WORK_W'(hst_pkg::HEADING_STEPS);
      end
    end
    turn = turn_work[hst_pkg::SHIFT_W-1:0];
  end

  // A right turn is the complementary left turn; a zero turn stays zero.
  always_comb begin
    if (s1_req_r == hst_pkg::REQ_RIGHT && turn != '0) begin
      shift = hst_pkg::SHIFT_W'(hst_pkg::HEADING_STEPS) - turn;
    end else begin
      shift = turn;
    end
  end

  hst_rotate u_rotate (
    .set_i (set_r),
    .shift (shift),
    .set_o (turned_set)
  );

  // Saturating adds: a carry out of the sum pins it at its maximum.
  assign fwd_add = {1'b0, fwd_sum_r} + (hst_pkg::SUM_W + 1)'(s1_amount_r);
  assign bwd_add = {1'b0, bwd_sum_r} + (hst_pkg::SUM_W + 1)'(s1_amount_r);

  always_comb begin
    set_nxt     = set_r;
    fwd_sum_nxt = fwd_sum_r;
    bwd_sum_nxt = bwd_sum_r;
    case (s1_req_r)
      hst_pkg::REQ_CLEAR: begin
        set_nxt     = hst_pkg::SET_RESET;
        fwd_sum_nxt = '0;
        bwd_sum_nxt = '0;
      end
      hst_pkg::REQ_FORWARD: begin
        fwd_sum_nxt = fwd_add[hst_pkg::SUM_W] ? '1 : fwd_add[hst_pkg::SUM_W-1:0];
      end
      hst_pkg::REQ_BACKWARD: begin
        bwd_sum_nxt = bwd_add[hst_pkg::SUM_W] ? '1 : bwd_add[hst_pkg::SUM_W-1:0];
      end
      hst_pkg::REQ_LEFT: begin
        set_nxt = turned_set;
      end
      hst_pkg::REQ_RIGHT: begin
        set_nxt = turned_set;
      end
      default: begin
        // Unknown requests leave the state alone and just report it.
        set_nxt = set_r;
      end
    endcase
  end

  // The best angle is taken from the set as it stands after this request.
  hst_best_angle u_best_angle (
    .set_i (set_nxt),
    .best  (best_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r     <= hst_pkg::SET_RESET;
      fwd_sum_r <= '0;
      bwd_sum_r <= '0;
    end else if (s1_fire) begin
      set_r     <= set_nxt;
      fwd_sum_r <= fwd_sum_nxt;
      bwd_sum_r <= bwd_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_fwd_r  <= fwd_sum_nxt;
      out_bwd_r  <= bwd_sum_nxt;
      out_best_r <= best_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_forward_total  = out_fwd_r;
  assign out_backward_total = out_bwd_r;
  assign out_best_angle     = out_best_r;

  // A clear leaves zero sums and a best angle of zero in the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r == hst_pkg::REQ_CLEAR) |=>
      (out_fwd_r == '0 && out_bwd_r == '0 && out_best_r == '0))
    else $error("clear did not return zero result");

  // Heading zero is always reachable.
  assert property (@(posedge clk) disable iff (!rst_n) set_r[0])
    else $error("heading zero dropped from the set");

  // Without a clear the set only gains headings.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !($past(s1_fire) && $past(s1_req_r) == hst_pkg::REQ_CLEAR)) |->
      ((set_r & $past(set_r)) == $past(set_r)))
    else $error("heading set lost a heading without a clear");

  // Without a clear the forward sum never goes down.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !($past(s1_fire) && $past(s1_req_r) == hst_pkg::REQ_CLEAR)) |->
      (fwd_sum_r >= $past(fwd_sum_r)))
    else $error("forward sum decreased without a clear");

  // Input is held off only while the input register holds a stalled request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a pending request");

endmodule

// File: dv/tb_reachable_heading_set_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reachable_heading_set_tracker: self-checking bench for the heading tracker
// Sends requests over the valid/ready input channel and keeps its own model of
// the reachable heading set and of the two distance sums. Every result is
// checked in order against the model. Both sides idle at random, and one
// phase holds the result channel off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_reachable_heading_set_tracker;

  localparam int CLK_HALF_NS     = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int IDLE_PCT        = 34;
  localparam int HOLD_OFF_CYCLES = 60;
  // The result register is loaded from the input register after acceptance, so
  // the drain after the last result is plenty to catch any stray output.
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;
  localparam int REQUEST_TARGET  = 1350;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  // Request codes above the defined ones; the block must treat them as no-ops.
  localparam logic [hst_pkg::REQ_W-1:0]    REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [hst_pkg::REQ_W-1:0]    REQ_UNKNOWN_LAST  = 3'd7;
  localparam logic [hst_pkg::AMOUNT_W-1:0] AMOUNT_MAX        = '1;

  // One result as it is expected on the output channel.
  typedef struct {
    hst_pkg::sum_t               forward_total;
    hst_pkg::sum_t               backward_total;
    logic [hst_pkg::ANGLE_W-1:0] best_angle;
  } heading_report_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [hst_pkg::REQ_W-1:0]    in_req_type;
  logic [hst_pkg::AMOUNT_W-1:0] in_amount;
  logic                         out_valid;
  logic                         out_ready;
  logic [hst_pkg::SUM_W-1:0]    out_forward_total;
  logic [hst_pkg::SUM_W-1:0]    out_backward_total;
  logic [hst_pkg::ANGLE_W-1:0]  out_best_angle;

  // Model state of the tracker, advanced once per accepted request.
  hst_pkg::heading_set_t model_headings;
  hst_pkg::sum_t         model_forward;
  hst_pkg::sum_t         model_backward;

  heading_report_t pending_reports[$];
  int              mismatches;
  int              requests_sent;

  // no_idle switches off random idling on both channels. hold_off_req asks
  // the receiver for one long stall; the receiver clears it when it starts.
  bit              no_idle;
  bit              hold_off_req;

  reachable_heading_set_tracker u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_amount          (in_amount),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_forward_total  (out_forward_total),
    .out_backward_total (out_backward_total),
    .out_best_angle     (out_best_angle)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the tracker
  // --------------------------------------------------------------------------

  // Sums stick at all ones instead of wrapping.
  function automatic hst_pkg::sum_t add_saturating(hst_pkg::sum_t acc,
                                                   logic [hst_pkg::AMOUNT_W-1:0] amt);
    logic [hst_pkg::SUM_W:0] total;
    total = {1'b0, acc} + amt;
    return total[hst_pkg::SUM_W] ? '1 : total[hst_pkg::SUM_W-1:0];
  endfunction

  // A turn may be taken or skipped, so the new set is the old set OR the old
  // set rotated toward higher headings by the shift. A shift of zero leaves
  // the set as it is, since a right shift by the full width yields zero.
  function automatic hst_pkg::heading_set_t turn_headings(hst_pkg::heading_set_t headings,
                                                          int unsigned shift);
    return headings | (headings << shift) |
           (headings >> (hst_pkg::HEADING_STEPS - shift));
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic heading_report_t advance_heading_model(
      logic [hst_pkg::REQ_W-1:0] req, logic [hst_pkg::AMOUNT_W-1:0] amt);
    heading_report_t report;
    int unsigned     turn;
    int unsigned     best;
    int unsigned     dev;
    turn = amt % hst_pkg::HEADING_STEPS;
    case (req)
      hst_pkg::REQ_CLEAR: begin
        model_headings = hst_pkg::SET_RESET;
        model_forward  = '0;
        model_backward = '0;
      end
      hst_pkg::REQ_FORWARD:  model_forward  = add_saturating(model_forward, amt);
      hst_pkg::REQ_BACKWARD: model_backward = add_saturating(model_backward, amt);
      hst_pkg::REQ_LEFT:     model_headings = turn_headings(model_headings, turn);
      hst_pkg::REQ_RIGHT: begin
        model_headings = turn_headings(model_headings,
                           (hst_pkg::HEADING_STEPS - turn) % hst_pkg::HEADING_STEPS);
      end
      default: ;
    endcase
    // Best angle is the widest deviation from heading zero either way round.
    best = 0;
    for (int i = 0; i < hst_pkg::HEADING_STEPS; i++) begin
      if (model_headings[i]) begin
        dev = (i > hst_pkg::HEADING_STEPS - i) ? hst_pkg::HEADING_STEPS - i : i;
        if (dev > best) best = dev;
      end
    end
    report.forward_total  = model_forward;
    report.backward_total = model_backward;
    report.best_angle     = best[hst_pkg::ANGLE_W-1:0];
    return report;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request from a falling edge, after optional idle cycles, and
  // holds it until a rising edge sees in_ready. The model is advanced at the
  // edge of acceptance. in_valid stays high on return; at the next falling edge,
  // before any rising edge, a next call drives it anew or the run's end lowers it.
  task automatic send_request(logic [hst_pkg::REQ_W-1:0] req,
                              logic [hst_pkg::AMOUNT_W-1:0] amt);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_amount   <= amt;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(advance_heading_model(req, amt));
    requests_sent++;
  endtask

  // A well formed case: a clear, then distances and turns with random content.
  // Turn amounts mostly lie below a full turn, some small so the best angle climbs
  // over several requests, and a share at or past a full turn exercise folding.
  task automatic send_heading_case(int steps);
    logic [hst_pkg::AMOUNT_W-1:0] amt;
    send_request(hst_pkg::REQ_CLEAR, hst_pkg::AMOUNT_W'($urandom_range(AMOUNT_MAX)));
    repeat (steps) begin
      if ($urandom_range(99) < 50) begin
        case ($urandom_range(9))
          0:       amt = hst_pkg::AMOUNT_W'($urandom_range(AMOUNT_MAX,
                                                           hst_pkg::HEADING_STEPS));
          1, 2, 3: amt = hst_pkg::AMOUNT_W'($urandom_range(8));
          default: amt = hst_pkg::AMOUNT_W'($urandom_range(hst_pkg::HEADING_STEPS - 1));
        endcase
        send_request($urandom_range(1) ? hst_pkg::REQ_LEFT : hst_pkg::REQ_RIGHT, amt);
      end else begin
        send_request($urandom_range(1) ? hst_pkg::REQ_FORWARD : hst_pkg::REQ_BACKWARD,
                     hst_pkg::AMOUNT_W'($urandom_range(AMOUNT_MAX)));
      end
    end
  endtask

  // Noise: any code, unknown ones included, with any amount.
  task automatic send_noise(int count);
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        send_request(hst_pkg::REQ_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST)),
                     hst_pkg::AMOUNT_W'($urandom_range(AMOUNT_MAX)));
      end else begin
        send_request(hst_pkg::REQ_W'($urandom_range(REQ_UNKNOWN_LAST)),
                     hst_pkg::AMOUNT_W'($urandom_range(AMOUNT_MAX)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // out_ready changes at falling edges only. A pending hold-off request keeps
  // it low for a long stretch while the sender keeps offering, so both
  // pipeline stages fill and in_ready drops.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string field, logic [hst_pkg::SUM_W-1:0] got,
                             logic [hst_pkg::SUM_W-1:0] want);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
      mismatches++;
    end
  endtask

  // Each accepted result is compared with the oldest expected one.
  always @(posedge clk) begin
    heading_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: result with none expected, forward %0d backward %0d angle %0d",
                   $realtime, out_forward_total, out_backward_total, out_best_angle);
        end
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("forward_total", out_forward_total, want.forward_total);
        check_field("backward_total", out_backward_total, want.backward_total);
        check_field("best_angle", hst_pkg::SUM_W'(out_best_angle),
                    hst_pkg::SUM_W'(want.best_angle));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every code, turns of zero, one, half and full turns, and
  // amounts past a full turn on both turns and distances.
  task automatic test_directed_edges();
    send_request(hst_pkg::REQ_CLEAR, '0);
    send_request(hst_pkg::REQ_FORWARD, '0);
    send_request(hst_pkg::REQ_FORWARD, AMOUNT_MAX);
    send_request(hst_pkg::REQ_BACKWARD, AMOUNT_MAX);
    send_request(hst_pkg::REQ_BACKWARD, 9'd1);
    // Turns of zero, in either direction, must leave the set alone.
    send_request(hst_pkg::REQ_LEFT, '0);
    send_request(hst_pkg::REQ_RIGHT, '0);
    // One step each way: headings 0, 1 and 359 reachable.
    send_request(hst_pkg::REQ_LEFT, 9'd1);
    send_request(hst_pkg::REQ_RIGHT, 9'd1);
    // A full turn folds to zero; the largest amount folds to 151.
    send_request(hst_pkg::REQ_LEFT, hst_pkg::AMOUNT_W'(hst_pkg::HEADING_STEPS));
    send_request(hst_pkg::REQ_LEFT, AMOUNT_MAX);
    send_request(hst_pkg::REQ_RIGHT, hst_pkg::AMOUNT_W'(hst_pkg::HEADING_STEPS));
    send_request(hst_pkg::REQ_RIGHT, AMOUNT_MAX);
    // Unknown codes change nothing and report the current state.
    for (int code = REQ_UNKNOWN_FIRST; code <= REQ_UNKNOWN_LAST; code++) begin
      send_request(hst_pkg::REQ_W'(code), (code % 2) ? AMOUNT_MAX : '0);
    end
    // A clear ignores its amount.
    send_request(hst_pkg::REQ_CLEAR, AMOUNT_MAX);
    // A half turn reaches the widest angle on its own.
    send_request(hst_pkg::REQ_LEFT, hst_pkg::AMOUNT_W'(hst_pkg::HALF_STEPS));
    send_request(hst_pkg::REQ_RIGHT, hst_pkg::AMOUNT_W'(hst_pkg::HEADING_STEPS - 1));
    // Alternating bit patterns on the amount.
    send_request(hst_pkg::REQ_FORWARD, 9'h155);
    send_request(hst_pkg::REQ_BACKWARD, 9'h0AA);
  endtask

  // Full rate on both channels: one request in and one result out per cycle.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (6) send_heading_case($urandom_range(30, 15));
    no_idle = 1'b0;
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    send_heading_case(40);
  endtask

  // Mostly well formed cases of random length, with bursts of noise between.
  task automatic test_random_mix();
    while (requests_sent < REQUEST_TARGET) begin
      if ($urandom_range(9) == 0) send_noise($urandom_range(6, 1));
      else                        send_heading_case($urandom_range(30, 2));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = hst_pkg::REQ_CLEAR;
    in_amount      = '0;
    no_idle        = 1'b0;
    hold_off_req   = 1'b0;
    mismatches     = 0;
    requests_sent  = 0;
    model_headings = hst_pkg::SET_RESET;
    model_forward  = '0;
    model_backward = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_back_to_back();
    test_output_hold_off();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;

    // Every expected result must arrive; a missing one ends in the timeout.
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("reachable_heading_set_tracker test passed");
    end else begin
      $display("reachable_heading_set_tracker test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, long stall and random idling included.
  initial begin
    #(RUN_LIMIT_NS);
    $display("reachable_heading_set_tracker test failed");
    $finish;
  end

endmodule
